### hw/rtl/y2r_pkg.sv
// ============================================================================
// y2r_pkg
// Shared types, coefficients and the saturating scale-down for the YUV to
// RGB converter.
// ============================================================================
package y2r_pkg;

    localparam int unsigned SampleW = 8;
    localparam int unsigned SumW    = 16;
    localparam int unsigned FracW   = 5;

    // Offsets removed from the samples
    localparam logic [SampleW-1:0] OFS_Y = 8'd16;
    localparam logic [SampleW-1:0] OFS_C = 8'd127;

    // BT.601 coefficients in 3.5 fixed point
    localparam logic signed [7:0] C_Y  = 8'sd37;
    localparam logic signed [7:0] C_RV = 8'sd51;
    localparam logic signed [7:0] C_GU = 8'sd13;
    localparam logic signed [7:0] C_GV = 8'sd26;
    localparam logic signed [7:0] C_BU = 8'sd65;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_CHROMA_PER_PIXEL = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_SWAP_CHROMA      = 1'b1;

    typedef struct packed {
        logic [SampleW-1:0] cr;
        logic [SampleW-1:0] cb;
        logic [SampleW-1:0] luma;
    } t_yuv;

    typedef struct packed {
        logic [SampleW-1:0] blue;
        logic [SampleW-1:0] green;
        logic [SampleW-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic frame_end;
        logic row_end;
    } t_marks;

    // Floor shift by FracW, then clamp to 0..255
    function automatic logic [SampleW-1:0] sat_shift(input logic signed [SumW-1:0] s);
        logic [SampleW-1:0] r;
        if (s[SumW-1]) begin
            r = '0;
        end else if (|s[SumW-2:FracW+SampleW]) begin
            r = '1;
        end else begin
            r = s[FracW+SampleW-1:FracW];
        end
        return r;
    endfunction

endpackage

### hw/rtl/y2r_lane.sv
// ============================================================================
// y2r_lane
// One pixel lane: removes offsets, forms the coefficient products into a
// register, then sums and saturates the three color channels.
// ============================================================================
module y2r_lane
    import y2r_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_yuv i_pix,
    output t_rgb o_rgb
);

    logic signed [9:0]      yd;
    logic signed [9:0]      ud;
    logic signed [9:0]      vd;
    logic signed [SumW-1:0] n_py;
    logic signed [SumW-1:0] n_pr;
    logic signed [SumW-1:0] n_pg;
    logic signed [SumW-1:0] n_pb;
    logic signed [SumW-1:0] r_py;
    logic signed [SumW-1:0] r_pr;
    logic signed [SumW-1:0] r_pg;
    logic signed [SumW-1:0] r_pb;
    logic signed [SumW-1:0] s_r;
    logic signed [SumW-1:0] s_g;
    logic signed [SumW-1:0] s_b;

    always_comb begin
        yd   = $signed({2'b00, i_pix.luma}) - $signed({2'b00, OFS_Y});
        ud   = $signed({2'b00, i_pix.cb})   - $signed({2'b00, OFS_C});
        vd   = $signed({2'b00, i_pix.cr})   - $signed({2'b00, OFS_C});
        n_py = SumW'(yd) * SumW'(C_Y);
        n_pr = SumW'(vd) * SumW'(C_RV);
        n_pg = SumW'(ud) * SumW'(C_GU) + SumW'(vd) * SumW'(C_GV);
        n_pb = SumW'(ud) * SumW'(C_BU);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_py <= n_py;
            r_pr <= n_pr;
            r_pg <= n_pg;
            r_pb <= n_pb;
        end
    end

    always_comb begin
        s_r         = r_py + r_pr;
        s_g         = r_py - r_pg;
        s_b         = r_py + r_pb;
        o_rgb.red   = sat_shift(s_r);
        o_rgb.green = sat_shift(s_g);
        o_rgb.blue  = sat_shift(s_b);
    end

endmodule

### hw/rtl/y2r_merge.sv
// ============================================================================
// y2r_merge
// Output register: joins both lane results and the frame marks into one
// result transaction and holds it until the sink takes it.
// ============================================================================
module y2r_merge
    import y2r_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_rgb   i_rgb_first,
    input  t_rgb   i_rgb_second,
    input  t_marks i_marks,
    input  logic   i_ready,
    output logic   o_en,
    output logic   o_vld,
    output t_rgb   o_rgb_first,
    output t_rgb   o_rgb_second,
    output t_marks o_marks
);

    logic   r_vld;
    t_rgb   r_rgb_first;
    t_rgb   r_rgb_second;
    t_marks r_marks;

    // Load when empty or when the held result leaves this cycle
    assign o_en = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_rgb_first  <= i_rgb_first;
            r_rgb_second <= i_rgb_second;
            r_marks      <= i_marks;
        end
    end

    assign o_vld        = r_vld;
    assign o_rgb_first  = r_rgb_first;
    assign o_rgb_second = r_rgb_second;
    assign o_marks      = r_marks;

endmodule

### hw/rtl/yuv_to_rgb_pixel_converter.sv
// Path: an accepted pixel pair passes the product register in each lane, then the output
// register. Throughput: one pixel pair per cycle while the master side is ready, set by
// these two registers; a stage advances when it is empty or when its contents move on,
// so a released stall costs no bubble.
// Reset (synchronous, active low) clears the stage valid flags and both
// configuration registers; no result is pending after reset.
// ============================================================================
// yuv_to_rgb_pixel_converter
// BT.601 YUV to RGB conversion of two adjacent pixels per transaction, with
// shared or per-pixel chroma and an optional U/V swap.
// ============================================================================
module yuv_to_rgb_pixel_converter
    import y2r_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Slave side
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // luma_first, luma_second, cb_first, cr_first, cb_second, cr_second
    input  logic [47:0]        i_s_tdata,
    input  logic               i_s_tlast,   // row_end
    input  logic               i_s_tuser,   // frame_end
    // Master side
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // red_first, green_first, blue_first, red_second, green_second, blue_second
    output logic [47:0]        o_m_tdata,
    output logic               o_m_tlast,   // row_end_out
    output logic               o_m_tuser,   // frame_end_out
    // Configuration write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic               i_cfg_data
);

    logic   r_chroma_per_pixel;
    logic   r_swap_chroma;
    logic   r_vld_a;
    t_marks r_marks_a;
    logic   en_a;
    logic   en_out;

    logic [SampleW-1:0] cb0;
    logic [SampleW-1:0] cr0;
    logic [SampleW-1:0] cb1;
    logic [SampleW-1:0] cr1;
    t_yuv   pix_first;
    t_yuv   pix_second;
    t_rgb   rgb_first;
    t_rgb   rgb_second;
    t_rgb   out_first;
    t_rgb   out_second;
    t_marks in_marks;
    t_marks out_marks;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_per_pixel <= 1'b0;
            r_swap_chroma      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHROMA_PER_PIXEL: r_chroma_per_pixel <= i_cfg_data;
                CFG_SWAP_CHROMA:      r_swap_chroma      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Chroma routing: swap each pair if asked, then share the first pair unless per-pixel
    always_comb begin
        if (r_swap_chroma) begin
            cb0 = i_s_tdata[31:24];
            cr0 = i_s_tdata[23:16];
            cb1 = i_s_tdata[47:40];
            cr1 = i_s_tdata[39:32];
        end else begin
            cb0 = i_s_tdata[23:16];
            cr0 = i_s_tdata[31:24];
            cb1 = i_s_tdata[39:32];
            cr1 = i_s_tdata[47:40];
        end
        pix_first.luma  = i_s_tdata[7:0];
        pix_first.cb    = cb0;
        pix_first.cr    = cr0;
        pix_second.luma = i_s_tdata[15:8];
        pix_second.cb   = r_chroma_per_pixel ? cb1 : cb0;
        pix_second.cr   = r_chroma_per_pixel ? cr1 : cr0;
        in_marks.row_end   = i_s_tlast;
        in_marks.frame_end = i_s_tuser;
    end

    // Product stage advances when empty or when it hands off to the output
    assign en_a       = !r_vld_a || en_out;
    assign o_s_tready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (en_a) begin
            r_vld_a <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_marks_a <= in_marks;
        end
    end

    y2r_lane u_lane_first (
        .i_clk (i_clk),
        .i_en  (en_a),
        .i_pix (pix_first),
        .o_rgb (rgb_first)
    );

    y2r_lane u_lane_second (
        .i_clk (i_clk),
        .i_en  (en_a),
        .i_pix (pix_second),
        .o_rgb (rgb_second)
    );

    y2r_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_vld_a),
        .i_rgb_first  (rgb_first),
        .i_rgb_second (rgb_second),
        .i_marks      (r_marks_a),
        .i_ready      (i_m_tready),
        .o_en         (en_out),
        .o_vld        (o_m_tvalid),
        .o_rgb_first  (out_first),
        .o_rgb_second (out_second),
        .o_marks      (out_marks)
    );

    assign o_m_tdata = {out_second.blue, out_second.green, out_second.red,
                        out_first.blue,  out_first.green,  out_first.red};
    assign o_m_tlast = out_marks.row_end;
    assign o_m_tuser = out_marks.frame_end;

endmodule

### hw/rtl/y2r_chk.sv
// ============================================================================
// y2r_chk
// Port-level checks on the converter's stream handshakes, bound to the top.
// ============================================================================
module y2r_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready
);

    // A result is never dropped while the sink stalls
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Input is taken whenever the output side can move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled although output is free");

    // An accepted pair reaches the output when the output register is free to load it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) ##1 (!o_m_tvalid || i_m_tready) |=> o_m_tvalid)
        else $error("accepted transaction did not reach output");

endmodule

bind yuv_to_rgb_pixel_converter y2r_chk u_y2r_chk (.*);

### tb/sv/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for yuv_to_rgb_pixel_converter. Pixel pairs stream in
// through the slave side, each one is converted by a local predictor using
// the current chroma settings, and every result on the master side is
// compared field by field in order. Both sides stall at random, and the
// chroma settings change between drained phases.
// ============================================================================
module testbench;
    import y2r_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 64;
    localparam int PHASE_PAIRS    = 105;
    localparam int RANDOM_PHASES  = 10;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic       frame_end;
        logic       row_end;
        logic [7:0] cr1;
        logic [7:0] cb1;
        logic [7:0] cr0;
        logic [7:0] cb0;
        logic [7:0] luma1;
        logic [7:0] luma0;
    } t_pixel_pair;

    // red0, green0, blue0, red1, green1, blue1, row end, frame end
    typedef logic [7:0][7:0] t_rgb_fields;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [47:0]          i_s_tdata   = '0;
    logic                 i_s_tlast   = 1'b0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [47:0]          o_m_tdata;
    logic                 o_m_tlast;
    logic                 o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CfgIdxW-1:0]   i_cfg_index = CFG_CHROMA_PER_PIXEL;
    logic                 i_cfg_data  = 1'b0;

    t_pixel_pair pending_pairs [$];
    t_rgb_fields expected_rgb [$];
    t_pixel_pair driven_pair;

    logic per_pixel_chroma;
    logic swap_uv;
    logic steady;

    int src_wait;
    int sink_wait;
    int hold_left;
    int stall_requests;
    int stalls_taken;
    int idle_cycles;
    int errors;
    int pairs_sent;
    int results_checked;
    int settings_used;

    string field_name [8] = '{"red_first", "green_first", "blue_first", "red_second",
                              "green_second", "blue_second", "row_end_out", "frame_end_out"};

    yuv_to_rgb_pixel_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Color conversion predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] scale_clamp(int acc);
        int scaled;
        scaled = acc >>> FracW;
        if (scaled < 0) return 8'd0;
        if (scaled > 255) return 8'd255;
        return 8'(scaled);
    endfunction

    function automatic t_rgb pixel_to_rgb(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
        int   luma_term;
        int   u;
        int   v;
        t_rgb px;
        luma_term = (int'(luma) - int'(OFS_Y)) * int'(C_Y);
        u         = int'(cb) - int'(OFS_C);
        v         = int'(cr) - int'(OFS_C);
        px.red    = scale_clamp(luma_term + int'(C_RV) * v);
        px.green  = scale_clamp(luma_term - (int'(C_GU) * u + int'(C_GV) * v));
        px.blue   = scale_clamp(luma_term + int'(C_BU) * u);
        return px;
    endfunction

    function automatic t_rgb_fields convert_pair(t_pixel_pair p);
        logic [7:0]  cb0, cr0, cb1, cr1;
        t_rgb        px0, px1;
        t_rgb_fields r;
        cb0 = swap_uv ? p.cr0 : p.cb0;
        cr0 = swap_uv ? p.cb0 : p.cr0;
        cb1 = swap_uv ? p.cr1 : p.cb1;
        cr1 = swap_uv ? p.cb1 : p.cr1;
        // Shared chroma: the second pixel reuses the first pair
        if (!per_pixel_chroma) begin
            cb1 = cb0;
            cr1 = cr0;
        end
        px0  = pixel_to_rgb(p.luma0, cb0, cr0);
        px1  = pixel_to_rgb(p.luma1, cb1, cr1);
        r[0] = px0.red;
        r[1] = px0.green;
        r[2] = px0.blue;
        r[3] = px1.red;
        r[4] = px1.green;
        r[5] = px1.blue;
        r[6] = {7'd0, p.row_end};
        r[7] = {7'd0, p.frame_end};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Slave-side driver: predict on each accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic holding;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            holding = i_s_tvalid && !o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                expected_rgb.push_back(convert_pair(driven_pair));
                pairs_sent++;
                src_wait = steady ? 0 : $urandom_range(0, 3);
            end
            if (!holding) begin
                if (src_wait == 0 && pending_pairs.size() > 0) begin
                    driven_pair = pending_pairs.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {driven_pair.cr1, driven_pair.cb1, driven_pair.cr0,
                                   driven_pair.cb0, driven_pair.luma1, driven_pair.luma0};
                    i_s_tlast  <= driven_pair.row_end;
                    i_s_tuser  <= driven_pair.frame_end;
                end else begin
                    i_s_tvalid <= 1'b0;
                    if (src_wait > 0) src_wait--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Master-side monitor and ready generator
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rgb_fields seen;
        t_rgb_fields want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_wait = 0;
            hold_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                seen = {7'd0, o_m_tuser, 7'd0, o_m_tlast, o_m_tdata};
                if (expected_rgb.size() == 0) begin
                    $display("%t: unexpected result, expected none, actual %h", $time, seen);
                    errors++;
                end else begin
                    want = expected_rgb.pop_front();
                    for (int i = 0; i < 8; i++) begin
                        if (seen[i] !== want[i]) begin
                            $display("%t: %s expected %0d actual %0d", $time, field_name[i],
                                     want[i], seen[i]);
                            errors++;
                        end
                    end
                    results_checked++;
                end
                sink_wait = steady ? 0 : $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stalls_taken != stall_requests) begin
                // Long back-pressure: let the pipeline fill and stall its input
                stalls_taken++;
                hold_left = LONG_HOLD - 1;
                i_m_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Register shadow, updated on each configuration transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            per_pixel_chroma = 1'b0;
            swap_uv          = 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CHROMA_PER_PIXEL: per_pixel_chroma = i_cfg_data;
                CFG_SWAP_CHROMA:      swap_uv          = i_cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_rgb.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_pair(logic [7:0] y0, logic [7:0] y1, logic [7:0] cb0, logic [7:0] cr0,
                            logic [7:0] cb1, logic [7:0] cr1, logic row_end, logic frame_end);
        t_pixel_pair p;
        p = '{frame_end: frame_end, row_end: row_end, cr1: cr1, cb1: cb1, cr0: cr0,
              cb0: cb0, luma1: y1, luma0: y0};
        pending_pairs.push_back(p);
    endtask

    // Write both registers back to back; valid stays high between them
    task automatic set_chroma_mode(logic per_pixel, logic swap);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_CHROMA_PER_PIXEL;
        i_cfg_data  <= per_pixel;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_SWAP_CHROMA;
        i_cfg_data  <= swap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Check on the falling edge, once the rising-edge updates have settled
    task automatic wait_drained();
        while (pending_pairs.size() > 0 || i_s_tvalid || expected_rgb.size() > 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_sample(logic [7:0] center);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1, 2:    return 8'(int'(center) + int'($urandom_range(0, 16)) - 8);
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_directed();
        add_pair(8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 1'b0);
        add_pair(8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   1'b1, 1'b0);
        add_pair(8'd16,  8'd16,  8'd127, 8'd127, 8'd127, 8'd127, 1'b0, 1'b1);
        add_pair(8'd235, 8'd235, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1, 1'b1);
        add_pair(8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 1'b0);
        add_pair(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 1'b0);
        add_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
        add_pair(8'd16,  8'd17,  8'd0,   8'd255, 8'd200, 8'd40,  1'b1, 1'b0);
        add_pair(8'd81,  8'd145, 8'd90,  8'd240, 8'd54,  8'd34,  1'b0, 1'b0);
        add_pair(8'd128, 8'd64,  8'd127, 8'd127, 8'd3,   8'd250, 1'b0, 1'b0);
        add_pair(8'd17,  8'd47,  8'd126, 8'd128, 8'd255, 8'd1,   1'b0, 1'b0);
        add_pair(8'd200, 8'd100, 8'd170, 8'd10,  8'd0,   8'd0,   1'b1, 1'b1);
    endtask

    task automatic add_random(int count);
        logic row_end;
        logic frame_end;
        for (int n = 0; n < count; n++) begin
            row_end   = ($urandom_range(0, 7) == 0);
            frame_end = row_end ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 63) == 0);
            add_pair(pick_sample(8'd16 + 8'($urandom_range(0, 1)) * 8'd219),
                     pick_sample(8'd128), pick_sample(8'd127), pick_sample(8'd127),
                     pick_sample(8'd127), pick_sample(8'd127), row_end, frame_end);
        end
    endtask

    initial begin
        steady = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_chroma_mode(1'b0, 1'b0);
        add_directed();
        wait_drained();
        set_chroma_mode(1'b1, 1'b1);
        add_directed();
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       set_chroma_mode(1'b1, 1'b0);
                1:       set_chroma_mode(1'b0, 1'b1);
                2:       set_chroma_mode(1'b0, 1'b0);
                3:       set_chroma_mode(1'b1, 1'b1);
                default: set_chroma_mode(1'($urandom), 1'($urandom));
            endcase
            steady = (ph == 2 || ph == 6);
            add_random(PHASE_PAIRS);
            if (ph == 3 || ph == 8) stall_requests++;
            // Hold the sender until every result of this phase is back
            wait_drained();
        end

        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_rgb.size() > 0) begin
            $display("%t: %0d results never arrived", $time, expected_rgb.size());
            errors++;
        end
        $display("Converted %0d pixel pairs under %0d chroma settings; %0d results checked.",
                 pairs_sent, settings_used, results_checked);
        $display("Random stalls on both sides, %0d long output holds, %0d errors.",
                 stalls_taken, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/y2r_pkg.sv
hw/rtl/y2r_lane.sv
hw/rtl/y2r_merge.sv
hw/rtl/yuv_to_rgb_pixel_converter.sv
hw/rtl/y2r_chk.sv
tb/sv/testbench.sv
